// ----- rtl/bpfa_pkg.sv -----
// Shared constants, codes and transaction types for the bitmap page frame allocator.
// No dependencies; imported by the top level, the find unit and the checker.
package bpfa_pkg;

    // Geometry
    localparam int PAGE_COUNT = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
    localparam int WORD_IDX_W = (PAGE_IDX_W > BIT_W) ? (PAGE_IDX_W - BIT_W) : 1;
    localparam int HELD_W     = $clog2(PAGE_COUNT + 1);

    // Port widths
    localparam int REG_W      = 17;
    localparam int CNT_W      = 17;
    localparam int ADDR_W     = 32;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int PAGE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_IDX_W = ADDR_W - PAGE_SHIFT;
    localparam int BND_W      = (HELD_W > REG_W) ? HELD_W : REG_W;

    // Reset value of the protected bound: first 20 MB stay reserved
    localparam logic [REG_W-1:0] LOWEST_RESET = REG_W'(20 * 1024 * 1024 / PAGE_BYTES);

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

    // Result status
    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_PAGE = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [PAGE_W-1:0] page;
    } bpfa_in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] page_address;
        logic [CNT_W-1:0]  free_count;
    } bpfa_out_t;

endpackage

// ----- rtl/bitmap_page_frame_allocator_top.sv -----
// Top level of the bitmap page frame allocator: sequencer, config registers, free counter.
// Depends on bpfa_pkg, bpfa_ram (bitmap store) and bpfa_find (word search unit).
//
// Usage
//   Command channel (in_valid/in_stall/in_data) carries one transaction per command:
//   allocate, free by byte address, or mark a page available. Result channel
//   (out_valid/out_stall/out_data) returns exactly one transaction per command with
//   status, allocated byte address and the free-page count after the command.
//   The config port (cfg_we/cfg_index/cfg_data) writes the page limit (index 0) and
//   the protected bound (index 1); other indexes are dropped. Write only while idle.
// Reset
//   rst_n clears the control state, then a fill pass writes all ones into the
//   bitmap, one 32-bit word per cycle over all MAP_WORDS (2048) words, with in_stall high.
// Timing
//   One command at a time; a new one is taken the cycle after each result loads.
//   Mark/free: read word, modify/write, load result.
//   Allocate: read words from the first one on until a free bit or the last word (up to 2047
//   words after the first); the bitmap RAM read port delivers one word per cycle to the find unit.
//   Commands rejected up front (bad alignment, out of range) go straight to loading the result.
// Back-pressure
//   The result sits in an output register; a new command is accepted while it
//   waits. If out_stall holds, the next result waits in its final state and the
//   block accepts nothing more until the register frees up.
module bitmap_page_frame_allocator_top
    import bpfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bpfa_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bpfa_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t                 state_reg,      state_next;
    logic [WORD_IDX_W-1:0]  clr_cnt_reg,    clr_cnt_next;
    logic [REG_W-1:0]       total_reg,      total_next;
    logic [REG_W-1:0]       lowest_reg,     lowest_next;
    logic [HELD_W-1:0]      held_reg,       held_next;
    logic [CMD_W-1:0]       cmd_reg,        cmd_next;
    logic [WORD_IDX_W-1:0]  word_reg,       word_next;
    logic [BIT_W-1:0]       bit_reg,        bit_next;
    logic [WORD_IDX_W-1:0]  first_word_reg, first_word_next;
    logic [WORD_IDX_W-1:0]  last_word_reg,  last_word_next;
    logic [BIT_W-1:0]       lo_bit_reg,     lo_bit_next;
    logic [BIT_W-1:0]       hi_bit_reg,     hi_bit_next;
    logic [STAT_W-1:0]      status_reg,     status_next;
    logic [ADDR_W-1:0]      addr_reg,       addr_next;
    logic                   out_valid_reg,  out_valid_next;
    bpfa_out_t              out_data_reg,   out_data_next;

    // Bitmap RAM ports
    logic                   ram_we;
    logic [WORD_IDX_W-1:0]  ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic                   ram_re;
    logic [WORD_IDX_W-1:0]  ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    // Find unit
    logic                   find_found;
    logic [BIT_W-1:0]       find_bit;

    // Decode helpers
    logic                   in_fire;
    logic                   out_fire;
    logic [BND_W-1:0]       total_ext;
    logic [BND_W-1:0]       lowest_ext;
    logic [BND_W-1:0]       eff_total;
    logic [BND_W-1:0]       end_m1;
    logic [ADDR_IDX_W-1:0]  free_idx;
    logic [PAGE_IDX_W-1:0]  free_pidx;
    logic [PAGE_IDX_W-1:0]  mark_pidx;
    logic [BND_W-1:0]       page_ext;
    logic [WORD_IDX_W+BIT_W-1:0] alloc_pidx;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpfa_find u_find (
        .word    (ram_rdata),
        .lo_en   (word_reg == first_word_reg),
        .lo_bit  (lo_bit_reg),
        .hi_en   (word_reg == last_word_reg),
        .hi_bit  (hi_bit_reg),
        .found   (find_found),
        .bit_idx (find_bit)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A page limit above the map size acts as the map size
    assign total_ext  = BND_W'(total_reg);
    assign lowest_ext = BND_W'(lowest_reg);
    assign eff_total  = (total_ext > BND_W'(PAGE_COUNT)) ? BND_W'(PAGE_COUNT) : total_ext;
    assign end_m1     = eff_total - 1'b1;
    assign free_idx   = in_data.address[ADDR_W-1:PAGE_SHIFT];
    assign free_pidx  = PAGE_IDX_W'(free_idx);
    assign mark_pidx  = PAGE_IDX_W'(in_data.page);
    assign page_ext   = BND_W'(in_data.page);
    assign alloc_pidx = {word_reg, find_bit};

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        total_next      = total_reg;
        lowest_next     = lowest_reg;
        held_next       = held_reg;
        cmd_next        = cmd_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        lo_bit_next     = lo_bit_reg;
        hi_bit_next     = hi_bit_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_fire ? 1'b0 : out_valid_reg;
        out_data_next   = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = word_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_TOTAL_PAGES)
            begin
                total_next = cfg_data;
            end
            else if (cfg_index == CFG_LOWEST_PAGE)
            begin
                lowest_next = cfg_data;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Fill pass: every frame starts out used
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = {WORD_BITS{1'b1}};
                if (clr_cnt_reg == WORD_IDX_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = in_data.command;
                    status_next     = ST_INVALID;
                    addr_next       = '0;
                    first_word_next = WORD_IDX_W'(lowest_ext >> BIT_W);
                    last_word_next  = WORD_IDX_W'(end_m1 >> BIT_W);
                    lo_bit_next     = lowest_reg[BIT_W-1:0];
                    hi_bit_next     = end_m1[BIT_W-1:0];
                    state_next      = S_DONE;
                    case (in_data.command)
                        CMD_ALLOC:
                        begin
                            if (lowest_ext < eff_total)
                            begin
                                word_next  = WORD_IDX_W'(lowest_ext >> BIT_W);
                                state_next = S_READ;
                            end
                            else
                            begin
                                status_next = ST_NONE_FREE;
                            end
                        end
                        CMD_FREE:
                        begin
                            if ((in_data.address[PAGE_SHIFT-1:0] == '0) &&
                                (ADDR_W'(free_idx) < ADDR_W'(eff_total)))
                            begin
                                word_next  = WORD_IDX_W'(free_pidx >> BIT_W);
                                bit_next   = free_pidx[BIT_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        CMD_MARK:
                        begin
                            if ((page_ext >= lowest_ext) && (page_ext < BND_W'(PAGE_COUNT)))
                            begin
                                word_next  = WORD_IDX_W'(mark_pidx >> BIT_W);
                                bit_next   = mark_pidx[BIT_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                ram_raddr  = word_reg;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (find_found)
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata | (WORD_BITS'(1) << find_bit);
                        held_next   = (held_reg != '0) ? held_reg - 1'b1 : held_reg;
                        addr_next   = ADDR_W'(alloc_pidx) << PAGE_SHIFT;
                        status_next = ST_DONE;
                        state_next  = S_DONE;
                    end
                    else if (word_reg == last_word_reg)
                    begin
                        status_next = ST_NONE_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // Next word read issued now; data arrives next cycle
                        ram_re    = 1'b1;
                        ram_raddr = word_reg + 1'b1;
                        word_next = word_reg + 1'b1;
                    end
                end
                else
                begin
                    if (ram_rdata[bit_reg])
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = ram_rdata & ~(WORD_BITS'(1) << bit_reg);
                        held_next   = held_reg + 1'b1;
                        status_next = ST_DONE;
                    end
                    else
                    begin
                        // Marking a free page is fine; freeing one is not
                        status_next = (cmd_reg == CMD_MARK) ? ST_DONE : ST_INVALID;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.page_address = addr_reg;
                    out_data_next.free_count   = CNT_W'(held_reg);
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            lowest_reg    <= LOWEST_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            lowest_reg    <= lowest_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        lo_bit_reg     <= lo_bit_next;
        hi_bit_reg     <= hi_bit_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        out_data_reg   <= out_data_next;
    end

endmodule

// ----- rtl/bpfa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bpfa_find.sv -----
// Search unit for allocate: lowest clear bit of one bitmap word inside a bit window.
// Depends on bpfa_pkg.
module bpfa_find
    import bpfa_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    input  logic                 lo_en,
    input  logic [BIT_W-1:0]     lo_bit,
    input  logic                 hi_en,
    input  logic [BIT_W-1:0]     hi_bit,
    output logic                 found,
    output logic [BIT_W-1:0]     bit_idx
);

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] free_bits;

    // Window: bits from lo_bit (first word) through hi_bit (last word)
    assign lo_mask   = lo_en ? ({WORD_BITS{1'b1}} << lo_bit) : {WORD_BITS{1'b1}};
    assign hi_mask   = hi_en ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit))
                             : {WORD_BITS{1'b1}};
    assign free_bits = ~word & lo_mask & hi_mask;

    // Priority encoder, lowest index wins
    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                found   = 1'b1;
                bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/bpfa_checker.sv -----
// Port-level assertions for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_top.
module bpfa_checker
    import bpfa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input bpfa_out_t out_data
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    // Only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_DONE) |-> (out_data.page_address == '0))
        else $error("nonzero page address on failed command");

    // Returned addresses are page aligned
    a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.page_address % PAGE_BYTES) == 0))
        else $error("page address not page aligned");

    // One command at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second command accepted back to back");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (.*);
